[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication on the rising clock, disabled while in reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert an implication whose consequent is checked in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rfcm_pkg.sv]
// ----------------------------------------------------------------------------
// rfcm_pkg
// Shared types and constants of the RF connectivity channel model.
// ----------------------------------------------------------------------------
package rfcm_pkg;

  localparam int NODES_DEF   = 64;
  localparam int POS_W       = 25;
  localparam int CNT_W       = 7;
  localparam int NCFG_W      = 7;
  localparam int RAND_W      = 16;
  localparam int PWR_W       = 8;
  localparam int NODE_W      = 6;
  localparam int QDEPTH      = 2;
  localparam logic [POS_W-1:0] FIELD_EDGE = 25'd32768000;
  localparam logic [CNT_W-1:0] CNT_MAX    = 7'd127;

  typedef enum logic [1:0] {
    CMD_TX    = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  // Power classes decided by the front end.
  typedef enum logic [1:0] {
    PWR_ALWAYS = 2'd0,
    PWR_TABLE  = 2'd1,
    PWR_NEVER  = 2'd2
  } pwr_cls_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    cmd_t                    cmd;
    logic                    valid_node;
    logic [NODE_W-1:0]       node;
    logic                    tx_bit;
    pwr_cls_t                pcls;
    logic [51:0]             thr_sq;
    logic [RAND_W-1:0]       rand_x;
    logic [RAND_W-1:0]       rand_y;
    logic [POS_W-1:0]        load_x;
    logic [POS_W-1:0]        load_y;
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_LINK,
    ST_COUNT,
    ST_FETCH,
    ST_RESULT
  } bk_state_t;

  // Squared range threshold, in squared Q9.16 position LSBs, for a table power setting.
  function automatic logic [51:0] thr_sq_of(input logic [2:0] idx);
    logic [51:0] t;
    begin
      case (idx)
        3'd0:    t = 52'd800 * 52'd800;
        3'd1:    t = 52'd600 * 52'd600;
        3'd2:    t = 52'd400 * 52'd400;
        3'd3:    t = 52'd200 * 52'd200;
        3'd4:    t = 52'd100 * 52'd100;
        3'd5:    t = 52'd50 * 52'd50;
        3'd6:    t = 52'd10 * 52'd10;
        default: t = '0;
      endcase
      thr_sq_of = t << 32;
    end
  endfunction

  // Walk step: floor(r / 500) by reciprocal multiply with one correction.
  function automatic logic [7:0] step_of(input logic [RAND_W-1:0] r);
    logic [33:0] p;
    logic [7:0]  q;
    logic [17:0] rem;
    begin
      p   = {18'd0, r} * 34'd33554;
      q   = p[31:24];
      rem = {2'd0, r} - {1'b0, q} * 18'd500;
      if (rem >= 18'd500) q = q + 8'd1;
      step_of = q;
    end
  endfunction

endpackage

[sv/rf_connectivity_channel_model_top.sv]
// Query, load, transmit with bit 0, stop of an idle node and any request for an
// invalid node pass READ, WALK, FETCH, RESULT; transmit with start bit adds a LINK
// sweep (read, square, compare per node) and a COUNT sweep (read, write back per
// node), stop of a sending node the COUNT sweep; sweeps cover len = min(node_count, NODES).
// One request runs at a time; a two-entry queue decouples input. Reset (rst_n low,
// synchronous) clears flags, sets node_count to 64, then a clearing pass zeroes positions, links, counts.
// ----------------------------------------------------------------------------
// rf_connectivity_channel_model_top
// Top level: front-end classifier and queue, back-end sweep engine.
// ----------------------------------------------------------------------------
module rf_connectivity_channel_model_top
  import rfcm_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [NCFG_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [NODE_W-1:0]   in_node,
  input  logic                in_tx_bit,
  input  logic [PWR_W-1:0]    in_power_setting,
  input  logic [RAND_W-1:0]   in_rand_x,
  input  logic [RAND_W-1:0]   in_rand_y,
  input  logic [POS_W-1:0]    in_load_x,
  input  logic [POS_W-1:0]    in_load_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_heard,
  output logic [CNT_W-1:0]    out_active_level
);

  logic q_valid, q_pop;
  req_t q_req;

  rfcm_front #(.NODES(NODES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_node, .in_tx_bit,
    .in_power_setting, .in_rand_x, .in_rand_y, .in_load_x, .in_load_y,
    .q_valid, .q_req, .q_pop
  );

  rfcm_back #(.NODES(NODES)) u_back (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data, .q_valid, .q_req, .q_pop,
    .out_valid, .out_stall, .out_heard, .out_active_level
  );

endmodule

[sv/rfcm_front.sv]
// ----------------------------------------------------------------------------
// rfcm_front
// Accepts requests, classifies command and power setting, and writes them
// into a short queue toward the back end.
// ----------------------------------------------------------------------------
module rfcm_front
  import rfcm_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [NODE_W-1:0]   in_node,
  input  logic                in_tx_bit,
  input  logic [PWR_W-1:0]    in_power_setting,
  input  logic [RAND_W-1:0]   in_rand_x,
  input  logic [RAND_W-1:0]   in_rand_y,
  input  logic [POS_W-1:0]    in_load_x,
  input  logic [POS_W-1:0]    in_load_y,
  output logic                q_valid,
  output req_t                q_req,
  input  logic                q_pop
);

  req_t             mem_r [QDEPTH];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  req_t             cls;
  logic             push;

  // Classify the incoming request.
  always_comb begin
    cls            = '0;
    cls.cmd        = cmd_t'(in_command);
    cls.valid_node = ({3'b0, in_node} < 9'(NODES));
    cls.node       = in_node;
    cls.tx_bit     = in_tx_bit;
    if (in_power_setting < 8'd70)      cls.pcls = PWR_ALWAYS;
    else if (in_power_setting > 8'd76) cls.pcls = PWR_NEVER;
    else                               cls.pcls = PWR_TABLE;
    cls.thr_sq     = thr_sq_of(3'(in_power_setting - 8'd70));
    cls.rand_x     = in_rand_x;
    cls.rand_y     = in_rand_y;
    cls.load_x     = in_load_x;
    cls.load_y     = in_load_y;
  end

  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[sv/rfcm_back.sv]
// ----------------------------------------------------------------------------
// rfcm_back
// Executes requests: walk step or load, link row sweep, counter sweep and result.
// ----------------------------------------------------------------------------
module rfcm_back
  import rfcm_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [NCFG_W-1:0]   cfg_data,
  input  logic                q_valid,
  input  req_t                q_req,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_heard,
  output logic [CNT_W-1:0]    out_active_level
);

  localparam int IW = $clog2(NODES);
  localparam int JW = IW + 1;

  bk_state_t         st_r, st_nxt;
  req_t              rq_r;
  logic [IW-1:0]     n_r;
  logic [NCFG_W-1:0] ncount_r;
  logic [JW-1:0]     j_r;
  logic [IW-1:0]     jx;
  logic [JW-1:0]     len;
  logic [1:0]        ph_r;
  logic              dec_r;
  logic [NODES-1:0]  send_r;
  logic [NODES-1:0]  row_r;

  // Node memories, zeroed by the clearing pass after reset.
  logic [POS_W-1:0]  px_mem [NODES];
  logic [POS_W-1:0]  py_mem [NODES];
  logic [CNT_W-1:0]  cnt_mem [NODES];
  logic [NODES-1:0]  link_mem [NODES];

  logic [POS_W-1:0]  px_q_r, py_q_r;
  logic [CNT_W-1:0]  cnt_q_r;
  logic [NODES-1:0]  link_q_r;
  logic [IW-1:0]     pos_ra, cnt_ra;

  logic              px_we, py_we, cnt_we, link_we;
  logic [IW-1:0]     pos_wa, link_wa;
  logic [POS_W-1:0]  px_wd, py_wd;
  logic [CNT_W-1:0]  cnt_wd, cnt_upd;
  logic [NODES-1:0]  link_wd;

  logic [POS_W-1:0]  sx_r, sy_r;
  logic [POS_W-1:0]  dx, dy;
  logic [49:0]       dx2_r, dy2_r;
  logic [POS_W:0]    nx, ny;
  logic              nx_ok, ny_ok, tx_walk;
  logic              out_v_r, heard_r;
  logic [CNT_W-1:0]  lvl_r;
  logic              sweep_done;

  assign cfg_ready = 1'b1;
  assign len = ({2'b0, ncount_r} < 9'(NODES)) ? JW'(ncount_r) : JW'(NODES);
  assign sweep_done = (j_r >= len);
  assign jx = j_r[IW-1:0];

  // Read addresses: the addressed node for its own reads, else the sweep index.
  assign pos_ra = (st_r == ST_READ) ? n_r : jx;
  assign cnt_ra = (st_r == ST_FETCH || st_r == ST_RESULT) ? n_r : jx;

  // Walk step on each axis, one bit wider so that a wrap is seen as leaving.
  assign tx_walk = rq_r.valid_node && (rq_r.cmd == CMD_TX);
  assign nx = {1'b0, px_q_r} + (POS_W+1)'(step_of(rq_r.rand_x));
  assign ny = {1'b0, py_q_r} + (POS_W+1)'(step_of(rq_r.rand_y));
  assign nx_ok = (nx != '0) && (nx < {1'b0, FIELD_EDGE});
  assign ny_ok = (ny != '0) && (ny < {1'b0, FIELD_EDGE});

  // Distance components against the position read for the sweep index.
  always_comb begin
    dx = (sx_r > px_q_r) ? sx_r - px_q_r : px_q_r - sx_r;
    dy = (sy_r > py_q_r) ? sy_r - py_q_r : py_q_r - sy_r;
  end

  // Saturating counter update.
  always_comb begin
    if (dec_r) cnt_upd = (cnt_q_r != '0) ? cnt_q_r - 1'b1 : cnt_q_r;
    else       cnt_upd = (cnt_q_r != CNT_MAX) ? cnt_q_r + 1'b1 : cnt_q_r;
  end

  // Memory write controls.
  always_comb begin
    px_we   = 1'b0;
    py_we   = 1'b0;
    pos_wa  = n_r;
    px_wd   = '0;
    py_wd   = '0;
    cnt_we  = 1'b0;
    cnt_wd  = '0;
    link_we = 1'b0;
    link_wa = n_r;
    link_wd = row_r;
    case (st_r)
      ST_CLEAR: begin
        px_we   = 1'b1;
        py_we   = 1'b1;
        pos_wa  = jx;
        cnt_we  = 1'b1;
        link_we = 1'b1;
        link_wa = jx;
        link_wd = '0;
      end
      ST_WALK: begin
        if (tx_walk) begin
          px_we = nx_ok;
          py_we = ny_ok;
          px_wd = nx[POS_W-1:0];
          py_wd = ny[POS_W-1:0];
        end else if (rq_r.valid_node && rq_r.cmd == CMD_LOAD) begin
          px_we = 1'b1;
          py_we = 1'b1;
          px_wd = rq_r.load_x;
          py_wd = rq_r.load_y;
        end
      end
      ST_LINK: link_we = sweep_done;
      ST_COUNT: begin
        if (!sweep_done && ph_r == 2'd1 && row_r[jx]) begin
          cnt_we = 1'b1;
          cnt_wd = cnt_upd;
        end
      end
      default: ;
    endcase
  end

  // Position memories.
  always_ff @(posedge clk) begin
    if (px_we) px_mem[pos_wa] <= px_wd;
    if (py_we) py_mem[pos_wa] <= py_wd;
    px_q_r <= px_mem[pos_ra];
    py_q_r <= py_mem[pos_ra];
  end

  // Counter memory.
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[jx] <= cnt_wd;
    cnt_q_r <= cnt_mem[cnt_ra];
  end

  // Link row memory.
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_q_r <= link_mem[n_r];
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR:  if (j_r == JW'(NODES - 1)) st_nxt = ST_IDLE;
      ST_IDLE:   if (q_valid) st_nxt = ST_READ;
      ST_READ:   st_nxt = ST_WALK;
      ST_WALK: begin
        if (!rq_r.valid_node) st_nxt = ST_FETCH;
        else if (rq_r.cmd == CMD_TX && rq_r.tx_bit) st_nxt = ST_LINK;
        else if (rq_r.cmd == CMD_STOP && send_r[n_r]) st_nxt = ST_COUNT;
        else st_nxt = ST_FETCH;
      end
      ST_LINK:   if (sweep_done) st_nxt = ST_COUNT;
      ST_COUNT:  if (sweep_done) st_nxt = ST_FETCH;
      ST_FETCH:  st_nxt = ST_RESULT;
      ST_RESULT: if (!out_v_r || !out_stall) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    q_pop = (st_r == ST_IDLE) && q_valid;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLEAR;
      ncount_r <= 7'd64;
      send_r   <= '0;
      out_v_r  <= 1'b0;
      ph_r     <= 2'd0;
      j_r      <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) ncount_r <= cfg_data;
      if (st_r == ST_RESULT && (!out_v_r || !out_stall)) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
      case (st_r)
        ST_CLEAR: j_r <= j_r + 1'b1;
        ST_IDLE: begin
          if (q_valid) begin
            rq_r <= q_req;
            n_r  <= IW'(q_req.node);
          end
        end
        ST_WALK: begin
          j_r   <= '0;
          ph_r  <= 2'd0;
          dec_r <= (rq_r.cmd == CMD_STOP);
          row_r <= link_q_r;
          sx_r  <= (tx_walk && nx_ok) ? nx[POS_W-1:0] : px_q_r;
          sy_r  <= (tx_walk && ny_ok) ? ny[POS_W-1:0] : py_q_r;
          if (tx_walk) send_r[n_r] <= rq_r.tx_bit;
          else if (rq_r.valid_node && rq_r.cmd == CMD_STOP) send_r[n_r] <= 1'b0;
        end
        ST_LINK: begin
          // Three phases per node: read, square, then compare.
          if (sweep_done) begin
            j_r  <= '0;
            ph_r <= 2'd0;
          end else begin
            case (ph_r)
              2'd0: ph_r <= 2'd1;
              2'd1: begin
                dx2_r <= 50'(dx) * 50'(dx);
                dy2_r <= 50'(dy) * 50'(dy);
                ph_r  <= 2'd2;
              end
              default: begin
                ph_r <= 2'd0;
                if (jx != n_r) begin
                  case (rq_r.pcls)
                    PWR_ALWAYS: row_r[jx] <= 1'b1;
                    PWR_TABLE:  row_r[jx] <=
                                  ({2'b0, dx2_r} + {2'b0, dy2_r}) < rq_r.thr_sq;
                    default:    row_r[jx] <= 1'b0;
                  endcase
                end
                j_r <= j_r + 1'b1;
              end
            endcase
          end
        end
        ST_COUNT: begin
          // Two phases per node: read the counter, then write it back.
          if (!sweep_done) begin
            if (ph_r == 2'd0) begin
              ph_r <= 2'd1;
            end else begin
              ph_r <= 2'd0;
              j_r  <= j_r + 1'b1;
            end
          end
        end
        ST_RESULT: begin
          if (!out_v_r || !out_stall) begin
            heard_r <= rq_r.valid_node && (cnt_q_r != '0);
            lvl_r   <= rq_r.valid_node ? cnt_q_r : '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_v_r;
  assign out_heard        = heard_r;
  assign out_active_level = lvl_r;

endmodule

[sv/rfcm_checker.sv]
// ----------------------------------------------------------------------------
// rfcm_checker
// Port-level checks of the channel model top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rfcm_checker
  import rfcm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_heard,
  input logic [CNT_W-1:0] out_active_level
);

  logic stalled;
  logic lvl_nz;

  assign stalled = out_valid && out_stall;
  assign lvl_nz  = (out_active_level != '0);

  `CHK_IMPLY(a_heard_lvl, clk, rst_n, out_valid, out_heard == lvl_nz, "heard mismatch")
  `CHK_NEXT(a_hold_v, clk, rst_n, stalled, out_valid, "stalled result dropped")
  `CHK_NEXT(a_hold_lvl, clk, rst_n, stalled, $stable(out_active_level), "level changed")
  `CHK_NEXT(a_hold_heard, clk, rst_n, stalled, $stable(out_heard), "heard changed")

endmodule

bind rf_connectivity_channel_model_top rfcm_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_heard, .out_active_level
);
